@@ rtl/core/aeg_pkg.sv @@
// Shared types, constants and helpers for the ADSR envelope gain block.
// Used by every module under rtl/core; depends on nothing else.
package aeg_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int STEP_W   = 16;
    localparam int STIME_W  = 24;
    localparam int LEVEL_W  = 17;
    localparam int NTIME_W  = 32;
    localparam int STAGE_W  = 3;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    localparam int DIV_Q_W   = 17;
    localparam int DIV_DEN_W = STIME_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

    localparam logic [LEVEL_W-1:0] UNITY = 17'h10000;

    typedef enum logic [STAGE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        REG_TIME_STEP = 3'd0,
        REG_ATTACK    = 3'd1,
        REG_DECAY     = 3'd2,
        REG_SUSTAIN   = 3'd3,
        REG_RELEASE   = 3'd4
    } t_reg_idx;

    typedef enum logic {
        POST_DIRECT,
        POST_FROM_UNITY
    } t_post;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_ADV,
        CS_EVAL,
        CS_MUL,
        CS_DIV_GO,
        CS_DIV_WAIT,
        CS_SCALE_L,
        CS_SCALE_R,
        CS_PUSH
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic adv;
        logic eval;
        logic mul;
        logic div_start;
        logic div_fin;
        logic scale_l;
        logic scale_r;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        clamp_level = (v > UNITY) ? UNITY : v;
    endfunction

endpackage

@@ rtl/core/aeg_div.sv @@
// Restoring divider producing one quotient bit per cycle.
// Depends on aeg_pkg for the operand widths.
module aeg_div
    import aeg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DIV_Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_quo;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 qbit;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_Q_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_INIT;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_LAST;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_NUM_W-1:DIV_Q_W];
            r_quo <= i_num[DIV_Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_Q_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder reached the divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

@@ rtl/core/aeg_datapath.sv @@
// Envelope datapath: stage and timer state, stage rules, level multiplier, sample
// multiplier shared by both channels, divider, output register. Depends on aeg_pkg, aeg_div.
module aeg_datapath
    import aeg_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [STEP_W-1:0]      i_time_step,
    input  logic [STIME_W-1:0]     i_attack_time,
    input  logic [STIME_W-1:0]     i_decay_time,
    input  logic [LEVEL_W-1:0]     i_sustain_level,
    input  logic [STIME_W-1:0]     i_release_time,
    input  logic [SAMPLE_BITS-1:0] i_sample_left,
    input  logic [SAMPLE_BITS-1:0] i_sample_right,
    input  logic                   i_playing,
    input  logic [NTIME_W-1:0]     i_time_played,
    input  logic [NTIME_W-1:0]     i_note_length,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [SAMPLE_BITS-1:0] o_out_left,
    output logic [SAMPLE_BITS-1:0] o_out_right,
    output logic [LEVEL_W-1:0]     o_envelope_level,
    output logic [STAGE_W-1:0]     o_envelope_stage
);

    localparam int CMP_W = (TIME_BITS > STIME_W) ? TIME_BITS : STIME_W;

    t_stage                 r_stage;
    logic [TIME_BITS-1:0]   r_timer;
    logic [SAMPLE_BITS-1:0] r_left;
    logic [SAMPLE_BITS-1:0] r_right;
    logic                   r_gate;
    logic                   r_force;
    logic [STIME_W-1:0]     r_a;
    logic [LEVEL_W-1:0]     r_b;
    logic [DIV_DEN_W-1:0]   r_den;
    t_post                  r_post;
    logic [DIV_NUM_W-1:0]   r_prod;
    logic [LEVEL_W-1:0]     r_level;
    logic [SAMPLE_BITS-1:0] r_scl_l;
    logic [SAMPLE_BITS-1:0] r_scl_r;
    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_o_left;
    logic [SAMPLE_BITS-1:0] r_o_right;
    logic [LEVEL_W-1:0]     r_o_level;
    t_stage                 r_o_stage;

    t_stage                 pre_stage;
    logic [TIME_BITS-1:0]   pre_timer;
    logic [TIME_BITS:0]     tsum;
    logic [TIME_BITS-1:0]   adv_timer;

    logic [CMP_W-1:0]       t_ext;
    logic [STIME_W-1:0]     t_lo;
    t_stage                 ev_stage;
    logic                   ev_clear;
    logic [LEVEL_W-1:0]     ev_level;
    logic                   ev_need_div;
    logic [STIME_W-1:0]     ev_a;
    logic [LEVEL_W-1:0]     ev_b;
    logic [DIV_DEN_W-1:0]   ev_den;
    t_post                  ev_post;

    logic                   div_done;
    logic [DIV_Q_W-1:0]     div_quot;
    logic [LEVEL_W-1:0]     fin_level;

    logic [SAMPLE_BITS-1:0]     sc_in;
    logic signed [SAMPLE_BITS+17:0] sc_prod;

    always_comb begin
        pre_stage = r_stage;
        pre_timer = r_timer;
        if (r_gate && r_stage == ST_IDLE) begin
            pre_stage = ST_ATTACK;
            pre_timer = '0;
        end
        if (r_force && pre_stage != ST_RELEASE && pre_stage != ST_IDLE) begin
            pre_stage = ST_RELEASE;
            pre_timer = '0;
        end
        tsum = {1'b0, pre_timer} + (TIME_BITS+1)'(i_time_step);
        if (pre_stage == ST_IDLE) begin
            adv_timer = pre_timer;
        end else if (tsum[TIME_BITS]) begin
            adv_timer = '1;
        end else begin
            adv_timer = tsum[TIME_BITS-1:0];
        end
    end

    always_comb begin
        t_ext       = CMP_W'(r_timer);
        t_lo        = t_ext[STIME_W-1:0];
        ev_stage    = r_stage;
        ev_clear    = 1'b0;
        ev_level    = '0;
        ev_need_div = 1'b0;
        ev_a        = t_lo;
        ev_b        = UNITY;
        ev_den      = i_attack_time;
        ev_post     = POST_DIRECT;
        unique case (r_stage)
            ST_ATTACK: begin
                if (t_ext >= CMP_W'(i_attack_time)) begin
                    ev_level = UNITY;
                    ev_stage = ST_DECAY;
                    ev_clear = 1'b1;
                end else begin
                    ev_need_div = 1'b1;
                end
            end
            ST_DECAY: begin
                ev_den = i_decay_time;
                if (t_ext >= CMP_W'(i_decay_time)) begin
                    ev_level = clamp_level(i_sustain_level);
                    ev_stage = ST_SUSTAIN;
                end else if (i_sustain_level <= UNITY) begin
                    ev_need_div = 1'b1;
                    ev_b        = UNITY - i_sustain_level;
                    ev_post     = POST_FROM_UNITY;
                end else begin
                    ev_level = UNITY;
                end
            end
            ST_SUSTAIN: begin
                ev_level = clamp_level(i_sustain_level);
            end
            ST_RELEASE: begin
                ev_den = i_release_time;
                ev_a   = i_release_time - t_lo;
                ev_b   = i_sustain_level;
                if (t_ext >= CMP_W'(i_release_time) || i_sustain_level == '0) begin
                    ev_stage = ST_IDLE;
                end else begin
                    ev_need_div = 1'b1;
                end
            end
            default: begin
                ev_level = '0;
            end
        endcase
    end

    aeg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        if (r_post == POST_FROM_UNITY) begin
            fin_level = UNITY - div_quot;
        end else begin
            fin_level = clamp_level(div_quot);
        end
        sc_in   = i_cmd.scale_r ? r_right : r_left;
        sc_prod = $signed(sc_in) * $signed({1'b0, r_level});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= ST_IDLE;
            r_timer  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.adv) begin
                r_stage <= pre_stage;
                r_timer <= adv_timer;
            end else if (i_cmd.eval) begin
                r_stage <= ev_stage;
                if (ev_clear) begin
                    r_timer <= '0;
                end
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_sample_left;
            r_right <= i_sample_right;
            r_gate  <= i_playing;
            r_force <= (i_time_played >= i_note_length) || !i_playing;
        end
        if (i_cmd.eval) begin
            r_level <= ev_level;
            r_a     <= ev_a;
            r_b     <= ev_b;
            r_den   <= ev_den;
            r_post  <= ev_post;
        end
        if (i_cmd.mul) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.div_fin) begin
            r_level <= fin_level;
        end
        if (i_cmd.scale_l) begin
            r_scl_l <= sc_prod[SAMPLE_BITS+15:16];
        end
        if (i_cmd.scale_r) begin
            r_scl_r <= sc_prod[SAMPLE_BITS+15:16];
        end
        if (i_cmd.push) begin
            r_o_left  <= r_scl_l;
            r_o_right <= r_scl_r;
            r_o_level <= r_level;
            r_o_stage <= r_stage;
        end
    end

    assign o_status.need_div = ev_need_div;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid      = r_ovalid;
    assign o_out_left       = r_o_left;
    assign o_out_right      = r_o_right;
    assign o_envelope_level = r_o_level;
    assign o_envelope_stage = r_o_stage;

endmodule

@@ rtl/core/aeg_ctrl.sv @@
// Sequencing state machine for the envelope datapath.
// Depends on aeg_pkg for the state, command and status types.
module aeg_ctrl
    import aeg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = CS_ADV;
                end
            end
            CS_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = CS_EVAL;
            end
            CS_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_div ? CS_MUL : CS_SCALE_L;
            end
            CS_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = CS_DIV_GO;
            end
            CS_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = CS_DIV_WAIT;
            end
            CS_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = CS_SCALE_L;
                end
            end
            CS_SCALE_L: begin
                o_cmd.scale_l = 1'b1;
                n_state       = CS_SCALE_R;
            end
            CS_SCALE_R: begin
                o_cmd.scale_r = 1'b1;
                n_state       = CS_PUSH;
            end
            CS_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/adsr_envelope_gain.sv @@
// Top level of the linear ADSR envelope gain block: register port and channels.
// Depends on aeg_pkg, aeg_ctrl, aeg_datapath and aeg_div.
//
//   channel   direction  beat content
//   s_axis    in         tdata: samples, note time, note length; tuser: playing
//   m_axis    out        tdata: scaled samples, envelope level, envelope stage
//   apb       in/out     five envelope registers, one per 32-bit word
//
// A result reaches the output register through the load, advance, evaluate, scale and
// push steps; a level that needs division adds the multiply step and the 17-step divider.
// A new beat is accepted once the previous result sits in the output register.
// Reset is synchronous and active low; it idles the envelope and restores
// register defaults. During an output stall the output register holds one result and
// the next one waits at the push step, which keeps the input stalled.
module adsr_envelope_gain
    import aeg_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // sample_left, sample_right, time_played, note_length, zero padding
    input  logic [((2*SAMPLE_BITS+2*NTIME_W+7)/8)*8-1:0] s_axis_tdata,
    // playing
    input  logic [0:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_left, out_right, envelope_level, envelope_stage, zero padding
    output logic [((2*SAMPLE_BITS+LEVEL_W+STAGE_W+7)/8)*8-1:0] m_axis_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    localparam int OUT_W = ((2*SAMPLE_BITS+LEVEL_W+STAGE_W+7)/8)*8;
    localparam int TP_LSB  = 2*SAMPLE_BITS;
    localparam int NL_LSB  = TP_LSB + NTIME_W;
    localparam int LVL_LSB = 2*SAMPLE_BITS;
    localparam int STG_LSB = LVL_LSB + LEVEL_W;
    localparam int OUT_PAD = OUT_W - STG_LSB - STAGE_W;

    logic [STEP_W-1:0]  r_time_step;
    logic [STIME_W-1:0] r_attack_time;
    logic [STIME_W-1:0] r_decay_time;
    logic [LEVEL_W-1:0] r_sustain_level;
    logic [STIME_W-1:0] r_release_time;

    logic                   wr_en;
    logic [2:0]             reg_sel;
    t_dp_cmd                cmd;
    t_dp_status             status;
    logic [SAMPLE_BITS-1:0] out_left;
    logic [SAMPLE_BITS-1:0] out_right;
    logic [LEVEL_W-1:0]     out_level;
    logic [STAGE_W-1:0]     out_stage;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step     <= STEP_W'(1);
            r_attack_time   <= '0;
            r_decay_time    <= '0;
            r_sustain_level <= UNITY;
            r_release_time  <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_TIME_STEP: r_time_step     <= pwdata[STEP_W-1:0];
                REG_ATTACK:    r_attack_time   <= pwdata[STIME_W-1:0];
                REG_DECAY:     r_decay_time    <= pwdata[STIME_W-1:0];
                REG_SUSTAIN:   r_sustain_level <= pwdata[LEVEL_W-1:0];
                REG_RELEASE:   r_release_time  <= pwdata[STIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TIME_STEP: prdata = APB_W'(r_time_step);
            REG_ATTACK:    prdata = APB_W'(r_attack_time);
            REG_DECAY:     prdata = APB_W'(r_decay_time);
            REG_SUSTAIN:   prdata = APB_W'(r_sustain_level);
            REG_RELEASE:   prdata = APB_W'(r_release_time);
            default:       prdata = '0;
        endcase
    end

    aeg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    aeg_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_time_step      (r_time_step),
        .i_attack_time    (r_attack_time),
        .i_decay_time     (r_decay_time),
        .i_sustain_level  (r_sustain_level),
        .i_release_time   (r_release_time),
        .i_sample_left    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_sample_right   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_playing        (s_axis_tuser[0]),
        .i_time_played    (s_axis_tdata[TP_LSB+:NTIME_W]),
        .i_note_length    (s_axis_tdata[NL_LSB+:NTIME_W]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_out_left       (out_left),
        .o_out_right      (out_right),
        .o_envelope_level (out_level),
        .o_envelope_stage (out_stage)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_stage, out_level, out_right, out_left};

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[LVL_LSB+:LEVEL_W] <= UNITY))
        else $error("envelope level above unity");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[STG_LSB+:STAGE_W] == ST_IDLE)
            |-> (m_axis_tdata[LVL_LSB+:LEVEL_W] == '0))
        else $error("idle stage with nonzero level");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

endmodule
